/* src/text_console_writer_assert.svh */
// Assertion macros used by the console writer port checker.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, reset-qualified.
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tcw_pkg.sv */
// Package for the text console writer: field widths, codes, states and shared types.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] SCROLL_ATTR  = 8'h0f;

    typedef enum logic [OP_W-1:0] {
        OP_PRINT      = 2'd0,
        OP_WRITE_CELL = 2'd1,
        OP_SET_CURSOR = 2'd2,
        OP_READ_CELL  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_EXEC,
        ST_RDWAIT,
        ST_SC_RD,
        ST_SC_WR,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic              scrolled;
        logic [ATTR_W-1:0] cell_attribute;
        logic [CHAR_W-1:0] cell_character;
    } t_result;

endpackage

/* src/tcw_cell_mem.sv */
// Cell store: one write port and one registered read port.
module tcw_cell_mem #(
    parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  tcw_pkg::t_mem_ctl           i_ctl,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tcw_ctrl.sv */
// Sequencer: cursor, address unit, clearing pass and scroll walk over the cell store.
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int AW      = $clog2(COLUMNS * ROWS),
    parameter int CW      = $clog2(COLUMNS),
    parameter int RW      = $clog2(ROWS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  tcw_pkg::t_op                i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_character,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_attribute,
    input  logic [tcw_pkg::COL_W-1:0]   i_column,
    input  logic [tcw_pkg::ROW_W-1:0]   i_row,
    output logic                        o_ready,
    input  logic                        i_res_ready,
    output logic                        o_done,
    output logic [CW-1:0]               o_cur_col,
    output logic [RW-1:0]               o_cur_row,
    output tcw_pkg::t_result            o_result,
    output tcw_pkg::t_mem_ctl           o_mem_ctl,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_mem_wdata,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_mem_rdata
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam logic [AW-1:0] A_COLS      = AW'(COLUMNS);
    localparam logic [AW-1:0] A_LAST      = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] A_LAST_MOVE = AW'(CELL_COUNT - COLUMNS - 1);
    localparam logic [CW-1:0] C_MAX       = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] R_MAX       = RW'(ROWS - 1);

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [CHAR_W-1:0] r_char, n_char;
    logic [ATTR_W-1:0] r_attr, n_attr;
    logic [CW-1:0]     r_tcol, n_tcol;
    logic [RW-1:0]     r_trow, n_trow;
    logic [CW-1:0]     r_cur_col, n_cur_col;
    logic [RW-1:0]     r_cur_row, n_cur_row;
    logic [AW-1:0]     r_ptr, n_ptr;
    t_result           r_res, n_res;

    logic          w_newline;
    logic          w_adv_line;
    logic          w_scroll;
    logic [CW-1:0] w_sel_col;
    logic [RW-1:0] w_sel_row;
    logic [CW-1:0] w_clamp_col;
    logic [RW-1:0] w_clamp_row;

    assign w_newline  = (r_char == NEWLINE_CODE);
    assign w_adv_line = w_newline || (r_cur_col == C_MAX);
    assign w_scroll   = w_adv_line && (r_cur_row == R_MAX);

    assign w_clamp_col = ({2'b00, i_column} > 9'(COLUMNS - 1)) ? C_MAX : CW'(i_column);
    assign w_clamp_row = ({3'b000, i_row} > 8'(ROWS - 1)) ? R_MAX : RW'(i_row);

    assign w_sel_col = (r_op == OP_PRINT) ? r_cur_col : r_tcol;
    assign w_sel_row = (r_op == OP_PRINT) ? r_cur_row : r_trow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_ptr     <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_char <= n_char;
        r_attr <= n_attr;
        r_tcol <= n_tcol;
        r_trow <= n_trow;
        r_res  <= n_res;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_ptr == A_LAST) n_state = ST_IDLE;
            ST_IDLE:   if (i_start) n_state = ST_ADDR;
            ST_ADDR:   n_state = ST_EXEC;
            ST_EXEC: begin
                unique case (r_op)
                    OP_PRINT:      n_state = w_scroll ? ST_SC_RD : ST_DONE;
                    OP_READ_CELL:  n_state = ST_RDWAIT;
                    OP_WRITE_CELL,
                    OP_SET_CURSOR: n_state = ST_DONE;
                    default:       n_state = ST_DONE;
                endcase
            end
            ST_RDWAIT: n_state = ST_DONE;
            ST_SC_RD:  n_state = ST_SC_WR;
            ST_SC_WR:  n_state = (r_ptr == A_LAST_MOVE) ? ST_FILL : ST_SC_RD;
            ST_FILL:   if (r_ptr == A_LAST) n_state = ST_DONE;
            ST_DONE:   if (i_res_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb begin
        n_op      = r_op;
        n_char    = r_char;
        n_attr    = r_attr;
        n_tcol    = r_tcol;
        n_trow    = r_trow;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_ptr     = r_ptr;
        n_res     = r_res;
        unique case (r_state)
            ST_CLEAR: n_ptr = (r_ptr == A_LAST) ? '0 : r_ptr + AW'(1);
            ST_IDLE: begin
                if (i_start) begin
                    n_op   = i_op;
                    n_char = i_character;
                    n_attr = i_attribute;
                    n_tcol = w_clamp_col;
                    n_trow = w_clamp_row;
                    n_res  = '0;
                end
            end
            ST_ADDR: n_ptr = AW'(w_sel_row) * A_COLS + AW'(w_sel_col);
            ST_EXEC: begin
                if (r_op == OP_PRINT) begin
                    if (w_scroll) begin
                        n_cur_col    = '0;
                        n_cur_row    = R_MAX;
                        n_ptr        = '0;
                        n_res.scrolled = 1'b1;
                    end else if (w_adv_line) begin
                        n_cur_col = '0;
                        n_cur_row = r_cur_row + RW'(1);
                    end else begin
                        n_cur_col = r_cur_col + CW'(1);
                    end
                end else if (r_op == OP_SET_CURSOR) begin
                    n_cur_col = r_tcol;
                    n_cur_row = r_trow;
                end
            end
            ST_RDWAIT: begin
                n_res.cell_character = i_mem_rdata[CHAR_W-1:0];
                n_res.cell_attribute = i_mem_rdata[CELL_W-1:CHAR_W];
            end
            ST_SC_WR: n_ptr = r_ptr + AW'(1);
            ST_FILL:  n_ptr = (r_ptr == A_LAST) ? '0 : r_ptr + AW'(1);
            ST_SC_RD, ST_DONE: ;
            default: ;
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        o_mem_ctl   = '0;
        o_mem_waddr = r_ptr;
        o_mem_wdata = '0;
        o_mem_raddr = r_ptr;
        unique case (r_state)
            ST_CLEAR: o_mem_ctl.wr_en = 1'b1;
            ST_EXEC: begin
                o_mem_wdata = {r_attr, r_char};
                if ((r_op == OP_PRINT && !w_newline) || r_op == OP_WRITE_CELL) begin
                    o_mem_ctl.wr_en = 1'b1;
                end
                if (r_op == OP_READ_CELL) begin
                    o_mem_ctl.rd_en = 1'b1;
                end
            end
            ST_SC_RD: begin
                o_mem_ctl.rd_en = 1'b1;
                o_mem_raddr     = r_ptr + A_COLS;
            end
            ST_SC_WR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_wdata     = {SCROLL_ATTR, i_mem_rdata[CHAR_W-1:0]};
            end
            ST_FILL: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_wdata     = {SCROLL_ATTR, SPACE_CODE};
            end
            ST_IDLE, ST_ADDR, ST_RDWAIT, ST_DONE: ;
            default: ;
        endcase
    end

    assign o_ready   = (r_state == ST_IDLE);
    assign o_done    = (r_state == ST_DONE);
    assign o_cur_col = r_cur_col;
    assign o_cur_row = r_cur_row;
    assign o_result  = r_res;

endmodule

/* src/text_console_writer.sv */
// Top level of the text console writer: stream ports, output register, sequencer and cell store.
//
// Input stream s_axis: one transaction is one console operation (print, write cell,
// set cursor, read cell). Output stream m_axis: exactly one result transaction per
// input, in order, carrying the cursor after the operation, read data and scroll flag.
// s_axis_tlast is echoed on m_axis_tlast.
// The sequencer walks each operation through accept, address, access and result states
// over the cell store, with a read wait for a read and a scroll walk (read and write of
// each moved cell, then a fill of the last row) for a print that scrolls; the result is
// then registered. A new operation is taken only once the previous one is back in idle.
// Reset: cursor goes to the top left; the cell store is cleared by a pass over all
// COLUMNS*ROWS cells during which s_axis_tready stays low.
// The result sits in an output register; the next input is taken while it waits, and
// the sequencer holds its following result until m_axis_tready frees the register.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // operation[1:0], character[9:2], attribute[17:10], column[24:18], row[29:25]
    input  logic [tcw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cursor_column[6:0], cursor_row[11:7], cell_character[19:12],
    // cell_attribute[27:20], scrolled[28]
    output logic [tcw_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast
);
    import tcw_pkg::*;

    localparam int AW = $clog2(COLUMNS * ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    logic                 w_accept;
    logic                 w_ready;
    logic                 w_done;
    logic                 w_res_ready;
    logic [CW-1:0]        w_cur_col;
    logic [RW-1:0]        w_cur_row;
    t_result              w_result;
    t_mem_ctl             w_mem_ctl;
    logic [AW-1:0]        w_mem_waddr;
    logic [AW-1:0]        w_mem_raddr;
    logic [CELL_W-1:0]    w_mem_wdata;
    logic [CELL_W-1:0]    w_mem_rdata;

    logic                 r_last;
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic                 r_m_last;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= s_axis_tlast;
        end
        if (w_done && w_res_ready) begin
            r_m_data <= {3'b000, w_result.scrolled, w_result.cell_attribute,
                         w_result.cell_character, ROW_W'(w_cur_row), COL_W'(w_cur_col)};
            r_m_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW),
        .CW      (CW),
        .RW      (RW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_op        (t_op'(s_axis_tdata[1:0])),
        .i_character (s_axis_tdata[9:2]),
        .i_attribute (s_axis_tdata[17:10]),
        .i_column    (s_axis_tdata[24:18]),
        .i_row       (s_axis_tdata[29:25]),
        .o_ready     (w_ready),
        .i_res_ready (w_res_ready),
        .o_done      (w_done),
        .o_cur_col   (w_cur_col),
        .o_cur_row   (w_cur_row),
        .o_result    (w_result),
        .o_mem_ctl   (w_mem_ctl),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    tcw_cell_mem #(
        .DEPTH (COLUMNS * ROWS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign s_axis_tready = w_ready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

/* src/tcw_checker.sv */
// Port-level checker for the text console writer and its bind.
`include "text_console_writer_assert.svh"

module tcw_port_checker #(
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [tcw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tcw_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic                            m_axis_tlast
);
    import tcw_pkg::*;

    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

    `TCW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after an input transaction")
    `TCW_ASSERT_SAME(a_cursor_row_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[11:7] <= ROW_MAX, "cursor row beyond last row")
    `TCW_ASSERT_SAME(a_scroll_cursor, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[28], m_axis_tdata[6:0] == 7'd0 && m_axis_tdata[11:7] == ROW_MAX, "scroll left cursor off the start of the last row")
    `TCW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind text_console_writer tcw_port_checker #(.ROWS(ROWS)) u_tcw_checker (.*);
